FILE: rtl/xor_checked_field_frame_parser_core_macros.svh
// Assertion macros shared by the parser checker.
`ifndef XOR_CHECKED_FIELD_FRAME_PARSER_CORE_MACROS_SVH
`define XOR_CHECKED_FIELD_FRAME_PARSER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define XCFP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("parser check failed");

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define XCFP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("parser check failed");

`endif

FILE: rtl/xcfp_pkg.sv
// Types, character codes and field table for the frame parser.
`default_nettype none
package xcfp_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_STX   = 8'h02;
	localparam logic [7:0] CH_ETX   = 8'h03;
	localparam logic [7:0] CH_US    = 8'h1F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DIG0  = 8'h30;
	localparam logic [7:0] CH_IF_HI = 8'h33;
	localparam logic [7:0] CH_CAM_HI = 8'h32;
	localparam logic [7:0] IF_BIAS  = 8'h2F;

	localparam logic [2:0] LAST_FIELD = 3'd6;

	localparam logic [1:0] KIND_FIELD  = 2'd0;
	localparam logic [1:0] KIND_ACCEPT = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [1:0] ERR_IFACE  = 2'd0;
	localparam logic [1:0] ERR_SEP    = 2'd1;
	localparam logic [1:0] ERR_CAMERA = 2'd2;
	localparam logic [1:0] ERR_ETX    = 2'd3;

	typedef enum logic [5:0] {
		PH_HUNT   = 6'b000001,
		PH_IFACE  = 6'b000010,
		PH_FIELD  = 6'b000100,
		PH_CAMERA = 6'b001000,
		PH_ETX    = 6'b010000,
		PH_CSUM   = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [2:0] field_index;
		logic [3:0] byte_position;
		logic [7:0] data_byte;
		logic [2:0] interface_num;
		logic [1:0] camera_num;
		logic       checksum_ok;
		logic [1:0] error_code;
	} result_t;

	function automatic logic [3:0] field_len(input logic [2:0] idx);
		logic [3:0] len;
		case (idx)
			3'd0: len = 4'd6;
			3'd1: len = 4'd4;
			3'd2: len = 4'd4;
			3'd3: len = 4'd6;
			3'd4: len = 4'd8;
			3'd5: len = 4'd10;
			3'd6: len = 4'd4;
			default: len = 4'd4;
		endcase
		return len;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/xcfp_out_buf.sv
// Two-entry result buffer: output register plus skid stage.
`default_nettype none
module xcfp_out_buf (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	input  xcfp_pkg::result_t     push_data,
	output logic                  space,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output xcfp_pkg::result_t     out_data
);
	import xcfp_pkg::*;

	logic    out_v_q;
	logic    skid_v_q;
	result_t out_q;
	result_t skid_q;
	logic    pop;

	assign pop       = out_v_q && out_ready;
	assign space     = !skid_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || pop) begin
			out_v_q <= push_valid;
		end else if (push_valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop)
				out_q <= skid_q;
		end else if (!out_v_q || pop) begin
			out_q <= push_data;
		end else if (push_valid) begin
			skid_q <= push_data;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/xor_checked_field_frame_parser_core.sv
// Each result is registered in the output buffer. Throughput: one byte per cycle while
// in_ready is high; the per-byte phase update is a single registered step.
// A two-entry output buffer keeps input open while one result waits; in_ready drops only
// when both entries are full. Reset returns to the STX hunt with held values and checksum
// cleared and the output buffer empty.
`default_nettype none
module xor_checked_field_frame_parser_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      result_kind,
	output logic [2:0]      field_index,
	output logic [3:0]      byte_position,
	output logic [7:0]      data_byte,
	output logic [2:0]      interface_num,
	output logic [1:0]      camera_num,
	output logic            checksum_ok,
	output logic [1:0]      error_code
);
	import xcfp_pkg::*;

	phase_t     phase_q, phase_d;
	logic [2:0] fidx_q, fidx_d;
	logic [3:0] offset_q, offset_d;
	logic [7:0] xor_q, xor_d;
	logic [2:0] held_if_q, held_if_d;
	logic [1:0] held_cam_q, held_cam_d;

	logic       take;
	logic       res_valid;
	result_t    res;
	result_t    out_res;
	logic       do_fail;
	logic [1:0] fail_code;
	logic [7:0] if_diff;

	assign take    = in_valid && in_ready;
	assign if_diff = rx_byte - IF_BIAS;

	always_comb begin
		phase_d    = phase_q;
		fidx_d     = fidx_q;
		offset_d   = offset_q;
		xor_d      = xor_q;
		held_if_d  = held_if_q;
		held_cam_d = held_cam_q;
		res_valid  = 1'b0;
		res        = '0;
		do_fail    = 1'b0;
		fail_code  = ERR_IFACE;

		case (phase_q)
			PH_IFACE: begin
				if (rx_byte inside {[CH_DIG0:CH_IF_HI]}) begin
					held_if_d = if_diff[2:0];
				end else if (rx_byte == CH_SPACE) begin
					held_if_d = '0;
				end else begin
					do_fail   = 1'b1;
					fail_code = ERR_IFACE;
				end
				if (!do_fail) begin
					xor_d    = xor_q ^ rx_byte;
					phase_d  = PH_FIELD;
					fidx_d   = '0;
					offset_d = '0;
				end
			end
			PH_FIELD: begin
				if (offset_q == '0) begin
					if (rx_byte != CH_US) begin
						do_fail   = 1'b1;
						fail_code = ERR_SEP;
					end else begin
						xor_d    = xor_q ^ rx_byte;
						offset_d = 4'd1;
					end
				end else if (rx_byte != CH_NUL) begin
					res_valid         = 1'b1;
					res.result_kind   = KIND_FIELD;
					res.field_index   = fidx_q;
					res.byte_position = offset_q - 4'd1;
					res.data_byte     = rx_byte;
					res.interface_num = held_if_q;
					xor_d             = xor_q ^ rx_byte;
					offset_d          = offset_q + 4'd1;
					// last byte of this field: advance to the next separator
					if (offset_q >= field_len(fidx_q)) begin
						offset_d = '0;
						if (fidx_q == LAST_FIELD)
							phase_d = PH_CAMERA;
						else
							fidx_d = fidx_q + 3'd1;
					end
				end
			end
			PH_CAMERA: begin
				if (offset_q == '0) begin
					if (rx_byte != CH_US) begin
						do_fail   = 1'b1;
						fail_code = ERR_SEP;
					end else begin
						xor_d    = xor_q ^ rx_byte;
						offset_d = 4'd1;
					end
				end else if (rx_byte != CH_NUL) begin
					if (rx_byte inside {[CH_DIG0:CH_CAM_HI]}) begin
						held_cam_d = rx_byte[1:0];
					end else if (rx_byte == CH_SPACE) begin
						held_cam_d = '0;
					end else begin
						do_fail   = 1'b1;
						fail_code = ERR_CAMERA;
					end
					if (!do_fail) begin
						xor_d    = xor_q ^ rx_byte;
						phase_d  = PH_ETX;
						offset_d = '0;
					end
				end
			end
			PH_ETX: begin
				if (rx_byte != CH_ETX) begin
					do_fail   = 1'b1;
					fail_code = ERR_ETX;
				end else begin
					xor_d   = xor_q ^ rx_byte;
					phase_d = PH_CSUM;
				end
			end
			PH_CSUM: begin
				res_valid         = 1'b1;
				res.result_kind   = KIND_ACCEPT;
				res.interface_num = held_if_q;
				res.camera_num    = held_cam_q;
				res.checksum_ok   = (xor_q == rx_byte);
				phase_d           = PH_HUNT;
				offset_d          = '0;
			end
			default: begin
				phase_d = PH_HUNT;
				if (rx_byte == CH_STX) begin
					phase_d  = PH_IFACE;
					offset_d = '0;
					xor_d    = '0;
				end
			end
		endcase

		// drop the frame, report an error result, and rescan the same byte as a hunt byte
		if (do_fail) begin
			res_valid       = 1'b1;
			res             = '0;
			res.result_kind = KIND_ERROR;
			res.error_code  = fail_code;
			held_if_d       = '0;
			held_cam_d      = '0;
			phase_d         = PH_HUNT;
			offset_d        = '0;
			xor_d           = xor_q;
			if (rx_byte == CH_STX) begin
				phase_d = PH_IFACE;
				xor_d   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			fidx_q     <= '0;
			offset_q   <= '0;
			xor_q      <= '0;
			held_if_q  <= '0;
			held_cam_q <= '0;
		end else if (take) begin
			phase_q    <= phase_d;
			fidx_q     <= fidx_d;
			offset_q   <= offset_d;
			xor_q      <= xor_d;
			held_if_q  <= held_if_d;
			held_cam_q <= held_cam_d;
		end
	end

	xcfp_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (take && res_valid),
		.push_data  (res),
		.space      (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_res)
	);

	assign result_kind   = out_res.result_kind;
	assign field_index   = out_res.field_index;
	assign byte_position = out_res.byte_position;
	assign data_byte     = out_res.data_byte;
	assign interface_num = out_res.interface_num;
	assign camera_num    = out_res.camera_num;
	assign checksum_ok   = out_res.checksum_ok;
	assign error_code    = out_res.error_code;

endmodule
`default_nettype wire

FILE: rtl/xcfp_checker.sv
// Port-level checker for the frame parser, bound to the top level.
`default_nettype none
`include "xor_checked_field_frame_parser_core_macros.svh"
module xcfp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] result_kind,
	input wire logic [2:0] field_index,
	input wire logic [3:0] byte_position,
	input wire logic [7:0] data_byte,
	input wire logic [2:0] interface_num,
	input wire logic [1:0] camera_num,
	input wire logic       checksum_ok,
	input wire logic [1:0] error_code
);
	import xcfp_pkg::*;

	logic        out_stall;
	logic        field_out;
	logic        error_out;
	logic        field_ok;
	logic        error_ok;
	logic        kind_ok;
	logic [24:0] out_payload;

	assign out_stall   = out_valid && !out_ready;
	assign field_out   = out_valid && result_kind == KIND_FIELD;
	assign error_out   = out_valid && result_kind == KIND_ERROR;
	assign out_payload = {result_kind, field_index, byte_position, data_byte,
		interface_num, camera_num, checksum_ok, error_code};
	assign field_ok    = byte_position <= 4'd9 && field_index <= LAST_FIELD &&
		camera_num == 2'd0 && error_code == 2'd0;
	assign error_ok    = interface_num == 3'd0 && data_byte == 8'd0 && !checksum_ok;
	assign kind_ok     = result_kind == KIND_FIELD || result_kind == KIND_ACCEPT ||
		result_kind == KIND_ERROR;

	`XCFP_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_payload))
	`XCFP_ASSERT_IMPL(a_field_range, field_out, field_ok)
	`XCFP_ASSERT_IMPL(a_kind_valid, out_valid, kind_ok)
	`XCFP_ASSERT_IMPL(a_error_clean, error_out, error_ok)
	`XCFP_ASSERT_IMPL(a_ready_when_empty, !out_valid, in_ready)

endmodule

bind xor_checked_field_frame_parser_core xcfp_checker u_xcfp_checker (.*);
`default_nettype wire
